>>> rtl/srl_pkg.sv
// Shared constants, result type and hex decode for the S3 record stream loader.
package srl_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POS_W   = 10;
    localparam int unsigned NIB_W   = 4;
    localparam int unsigned IDX_W   = POS_W - 1;

    localparam logic [CHAR_W-1:0] NEWLINE_CHAR   = 8'd10;
    localparam logic [CHAR_W-1:0] LOWER_A_CHAR   = 8'd97;
    localparam logic [CHAR_W-1:0] UPPER_A_CHAR   = 8'd65;
    localparam logic [CHAR_W-1:0] LOWER_OFFSET   = 8'd87;
    localparam logic [CHAR_W-1:0] UPPER_OFFSET   = 8'd55;
    localparam logic [CHAR_W-1:0] DIGIT_OFFSET   = 8'd48;
    localparam logic [POS_W-1:0]  POS_TYPE       = 10'd1;
    localparam logic [POS_W-1:0]  POS_COUNT_HI   = 10'd2;
    localparam logic [POS_W-1:0]  POS_COUNT_LO   = 10'd3;
    localparam logic [POS_W-1:0]  POS_ADDR_FIRST = 10'd4;
    localparam logic [POS_W-1:0]  DATA_START     = 10'd12;
    localparam logic [POS_W-1:0]  POS_MAX        = 10'd1023;
    localparam logic [BYTE_W-1:0] COUNT_OVERHEAD = 8'd5;
    localparam logic [NIB_W-1:0]  TYPE_S3        = 4'd3;

    // One decoded data byte headed for the output register
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] address;
        logic [BYTE_W-1:0] data;
    } t_result;

    // Lenient hex decode: non-hex characters still map to some nibble
    function automatic logic [NIB_W-1:0] hex_nibble(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        if (c >= LOWER_A_CHAR) begin
            v = c - LOWER_OFFSET;
        end else if (c >= UPPER_A_CHAR) begin
            v = c - UPPER_OFFSET;
        end else begin
            v = c - DIGIT_OFFSET;
        end
        return v[NIB_W-1:0];
    endfunction

endpackage

>>> rtl/srl_if.sv
// Valid/ready channel interfaces for characters in and decoded bytes out.
interface srl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface srl_write_if;
    logic        valid;
    logic        ready;
    logic [31:0] write_address;
    logic [7:0]  write_byte;

    modport source (output valid, output write_address, output write_byte, input ready);
    modport sink   (input valid, input write_address, input write_byte, output ready);
endinterface

>>> rtl/s_record_stream_loader.sv
// Top level of the S3 record stream loader: input stage, parser and output register.
// Usage:
//   i_char_req carries one ASCII character per request; a newline (10) ends a line.
//   o_wr_req carries one (write_address, write_byte) request for every data byte
//   of an S3 record; other record types, header fields and checksum give nothing.
//   Both channels use valid/ready; a request moves when both are high at a clock edge.
// Timing:
//   A character accepted into the input register is parsed combinationally from
//   there; its byte, if any, is registered in the output register behind o_wr_req.
//   One character per cycle is sustained while o_wr_req is ready: the input
//   register feeds a single parse step that writes straight to the output register.
// Reset (synchronous, i_rst_n low): both stages empty, line position, type,
//   count and skip flag cleared, as at the start of a line.
// Stall: while o_wr_req is held valid and not ready, the parser stops on every
//   character; the input register holds its character (or takes one if it was
//   empty) and ready stays low until the output request is taken.
module s_record_stream_loader (
    input  logic         i_clk,
    input  logic         i_rst_n,
    srl_char_if.sink     i_char_req,
    srl_write_if.source  o_wr_req
);
    import srl_pkg::*;

    logic              w_in_valid;
    logic [CHAR_W-1:0] w_in_char;
    logic              w_advance;
    t_result           w_result;

    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;
    logic [BYTE_W-1:0] r_out_byte;

    // Parser moves when it has a character and the output slot is free or draining
    assign w_advance = w_in_valid && (!r_out_valid || o_wr_req.ready);

    srl_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_char_req (i_char_req),
        .i_advance  (w_advance),
        .o_valid    (w_in_valid),
        .o_char     (w_in_char)
    );

    srl_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_char    (w_in_char),
        .o_result  (w_result)
    );

    // Output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_result.valid;
        end else if (o_wr_req.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_result.valid) begin
            r_out_addr <= w_result.address;
            r_out_byte <= w_result.data;
        end
    end

    assign o_wr_req.valid         = r_out_valid;
    assign o_wr_req.write_address = r_out_addr;
    assign o_wr_req.write_byte    = r_out_byte;

`ifndef SYNTHESIS
    // A waiting output request is never overwritten by the parser
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_wr_req.ready) |-> !w_advance)
        else $error("output request overwritten while stalled");

    // The parser only steps on a held character
    a_advance_has_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |-> w_in_valid)
        else $error("parser stepped without a character");

    // A produced byte shows up as an output request on the next cycle
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_result.valid |=> r_out_valid)
        else $error("produced byte did not reach the output register");
`endif

endmodule

>>> rtl/srl_in_stage.sv
// Input register: captures one character request and holds it until the parser takes it.
module srl_in_stage (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    srl_char_if.sink                  i_char_req,
    input  logic                      i_advance,
    output logic                      o_valid,
    output logic [srl_pkg::CHAR_W-1:0] o_char
);
    import srl_pkg::*;

    logic              r_valid;
    logic [CHAR_W-1:0] r_char;
    logic              w_take;

    // Accept when empty or when the held request moves on this cycle
    assign i_char_req.ready = !r_valid || i_advance;
    assign w_take           = i_char_req.valid && i_char_req.ready;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_char <= i_char_req.char_in;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;

endmodule

>>> rtl/srl_parser.sv
// Line parser: tracks position, type, count and address; builds the data byte result.
module srl_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  logic [srl_pkg::CHAR_W-1:0] i_char,
    output srl_pkg::t_result           o_result
);
    import srl_pkg::*;

    logic [POS_W-1:0]  r_pos;
    logic [NIB_W-1:0]  r_type;
    logic [BYTE_W-1:0] r_count;
    logic [ADDR_W-1:0] r_addr;
    logic [NIB_W-1:0]  r_high;
    logic              r_skip;

    logic [POS_W-1:0]  n_pos;
    logic [NIB_W-1:0]  n_type;
    logic [BYTE_W-1:0] n_count;
    logic [ADDR_W-1:0] n_addr;
    logic [NIB_W-1:0]  n_high;
    logic              n_skip;

    logic [NIB_W-1:0]  w_nib;
    logic [POS_W-1:0]  w_rel;
    logic [IDX_W-1:0]  w_idx;
    logic [BYTE_W-1:0] w_ndata;
    logic              w_newline;
    logic              w_in_data;

    assign w_nib     = hex_nibble(i_char);
    assign w_newline = (i_char == NEWLINE_CHAR);
    assign w_rel     = r_pos - DATA_START;
    assign w_idx     = w_rel[POS_W-1:1];
    assign w_ndata   = (r_count >= COUNT_OVERHEAD) ? (r_count - COUNT_OVERHEAD) : '0;
    assign w_in_data = (r_pos >= DATA_START) && (r_pos != POS_MAX);

    // Next state and result for the character at the head of the input register
    always_comb begin
        n_pos            = r_pos;
        n_type           = r_type;
        n_count          = r_count;
        n_addr           = r_addr;
        n_high           = r_high;
        n_skip           = r_skip;
        o_result.valid   = 1'b0;
        o_result.address = r_addr + ADDR_W'(w_idx);
        o_result.data    = {r_high, w_nib};
        if (w_newline) begin
            n_pos  = '0;
            n_skip = 1'b0;
        end else begin
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + 1'b1;
            end
            if (!r_skip) begin
                if (r_pos == POS_TYPE) begin
                    n_type = i_char[NIB_W-1:0];
                    n_skip = (i_char[NIB_W-1:0] != TYPE_S3);
                end else if (r_pos == POS_COUNT_HI) begin
                    n_count = {w_nib, {NIB_W{1'b0}}};
                end else if (r_pos == POS_COUNT_LO) begin
                    n_count = {r_count[BYTE_W-1:NIB_W], w_nib};
                end else if (r_pos >= POS_ADDR_FIRST && r_pos < DATA_START) begin
                    n_addr = {r_addr[ADDR_W-NIB_W-1:0], w_nib};
                end else if (w_in_data) begin
                    if (!r_pos[0]) begin
                        n_high = w_nib;
                    end else if (w_idx < {1'b0, w_ndata}) begin
                        o_result.valid = i_advance;
                    end
                end
            end
        end
    end

    // All parser state resets to the start of a line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_type  <= '0;
            r_count <= '0;
            r_addr  <= '0;
            r_high  <= '0;
            r_skip  <= 1'b0;
        end else if (i_advance) begin
            r_pos   <= n_pos;
            r_type  <= n_type;
            r_count <= n_count;
            r_addr  <= n_addr;
            r_high  <= n_high;
            r_skip  <= n_skip;
        end
    end

`ifndef SYNTHESIS
    // A byte only comes out of an S3 line in the data field
    a_result_in_s3_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (!r_skip && r_type == TYPE_S3 && w_in_data && r_pos[0]))
        else $error("data byte outside an S3 data field");

    // A newline always returns to the start of the line, not skipping
    a_newline_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && w_newline) |=> (r_pos == '0 && !r_skip))
        else $error("newline did not restart the line");

    // Position holds while the parser is stalled
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_advance) |=> $stable(r_pos))
        else $error("line position moved without a request");
`endif

endmodule
